// File: sv/sfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16/MODBUS byte step for the sync-word frame parser.
package sfp_pkg;

  localparam int MAX_FRAME_DEF = 128;

  localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_SEARCHING  = 3'd0,
    ST_COLLECTING = 3'd1,
    ST_GOOD       = 3'd2,
    ST_CRC_BAD    = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_SYNC0  = 3'd0,
    PH_SYNC1  = 3'd1,
    PH_HEADER = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRCLO  = 3'd4,
    PH_CRCHI  = 3'd5
  } phase_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/sync_word_crc16_frame_parser_top.sv
`timescale 1ns / 1ps
// Sync-word frame parser with CRC-16/MODBUS check and payload read-back.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   kind, rx_byte, read_index
//   output   out_valid  out_stall  status, payload_length, read_byte, read_valid
//
// One request per cycle is taken while in_stall is low; each result passes the parse
// stage, then the output register that also gets the registered payload RAM read.
// The payload RAM holds two banks: a frame is collected into one while reads see the
// other, and a good CRC flips the bank pointer instead of copying the payload.
// Reset is synchronous and clears the parser phase, bank pointer, stored length and valids.
// A stalled result holds the output register; once the parse stage is also full, the
// input is stalled in the same cycle.
module sync_word_crc16_frame_parser_top
  import sfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic [6:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [6:0] payload_length,
  output logic [7:0] read_byte,
  output logic       read_valid
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int IW = (AW > 7) ? AW : 7;
  localparam int RAM_DEPTH = 2 ** (AW + 1);
  localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME - 9);

  // parser state
  phase_t         phase, phase_next;
  logic [AW-1:0]  pos, pos_next;
  logic [7:0]     len_lo, len_lo_next;
  logic [AW-1:0]  data_len, data_len_next;
  logic [15:0]    crc, crc_next;
  logic [7:0]     crc_lo, crc_lo_next;
  logic [AW-1:0]  stored_len, stored_len_next;
  logic           bank, bank_next;

  // pipeline registers
  logic           s1_valid;
  status_t        s1_status;
  logic [6:0]     s1_plen;
  logic           s1_rvalid;

  logic           accept;
  logic           s1_adv;
  logic           take_rx;
  status_t        status_next;
  logic           coll_wr;
  logic [15:0]    full_len;
  logic [IW-1:0]  idx_ext;
  logic [IW-1:0]  stored_ext;
  logic [IW-1:0]  stored_next_ext;
  logic           rvalid_next;
  logic [7:0]     ram_q;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign take_rx  = accept && (kind == KIND_RX);

  assign full_len        = {rx_byte, len_lo};
  assign idx_ext         = IW'(read_index);
  assign stored_ext      = IW'(stored_len);
  assign stored_next_ext = IW'(stored_len_next);

  // next phase
  always_comb begin
    phase_next = phase;
    if (take_rx) begin
      case (phase)
        PH_SYNC0: begin
          if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (rx_byte == SYNC_SECOND) phase_next = PH_HEADER;
          else if (rx_byte != SYNC_FIRST) phase_next = PH_SYNC0;
        end
        PH_HEADER: begin
          if (pos == AW'(6)) begin
            if (full_len > LEN_LIMIT) phase_next = PH_SYNC0;
            else if (full_len == 16'd0) phase_next = PH_CRCLO;
            else phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos + AW'(1) == data_len + AW'(7)) phase_next = PH_CRCLO;
        end
        PH_CRCLO: phase_next = PH_CRCHI;
        PH_CRCHI: phase_next = PH_SYNC0;
        default:  phase_next = PH_SYNC0;
      endcase
    end
  end

  // datapath and result fields
  always_comb begin
    pos_next        = pos;
    len_lo_next     = len_lo;
    data_len_next   = data_len;
    crc_next        = crc;
    crc_lo_next     = crc_lo;
    stored_len_next = stored_len;
    bank_next       = bank;
    coll_wr         = 1'b0;
    status_next     = ST_SEARCHING;
    rvalid_next     = 1'b0;
    if (kind == KIND_READ) begin
      status_next = (phase == PH_SYNC0 || phase == PH_SYNC1) ? ST_SEARCHING : ST_COLLECTING;
      rvalid_next = idx_ext < stored_ext;
    end else begin
      case (phase)
        PH_SYNC0: status_next = ST_SEARCHING;
        PH_SYNC1: begin
          if (rx_byte == SYNC_SECOND) begin
            pos_next    = AW'(2);
            crc_next    = CRC_INIT;
            status_next = ST_COLLECTING;
          end
        end
        PH_HEADER: begin
          crc_next    = crc16_step(crc, rx_byte);
          coll_wr     = (pos >= AW'(4));
          pos_next    = pos + AW'(1);
          status_next = ST_COLLECTING;
          if (pos == AW'(5)) begin
            len_lo_next = rx_byte;
          end else if (pos == AW'(6)) begin
            data_len_next = full_len[AW-1:0];
            if (full_len > LEN_LIMIT) status_next = ST_TOO_LONG;
          end
        end
        PH_DATA: begin
          crc_next    = crc16_step(crc, rx_byte);
          coll_wr     = 1'b1;
          pos_next    = pos + AW'(1);
          status_next = ST_COLLECTING;
        end
        PH_CRCLO: begin
          crc_lo_next = rx_byte;
          status_next = ST_COLLECTING;
        end
        PH_CRCHI: begin
          if ({rx_byte, crc_lo} == crc) begin
            stored_len_next = data_len + AW'(3);
            bank_next       = ~bank;
            status_next     = ST_GOOD;
          end else begin
            status_next = ST_CRC_BAD;
          end
        end
        default: status_next = ST_SEARCHING;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC0;
      bank       <= 1'b0;
      stored_len <= '0;
      pos        <= '0;
      crc        <= CRC_INIT;
    end else if (accept) begin
      phase      <= phase_next;
      bank       <= bank_next;
      stored_len <= stored_len_next;
      pos        <= pos_next;
      crc        <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_lo   <= len_lo_next;
      data_len <= data_len_next;
      crc_lo   <= crc_lo_next;
    end
  end

  // collect into the idle bank, read from the live one
  sfp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (take_rx && coll_wr),
    .wr_addr ({~bank, pos - AW'(4)}),
    .wr_data (rx_byte),
    .rd_en   (accept),
    .rd_addr ({bank, idx_ext[AW-1:0]}),
    .rd_data (ram_q)
  );

  // parse stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_plen   <= stored_next_ext[6:0];
      s1_rvalid <= rvalid_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status         <= s1_status;
      payload_length <= s1_plen;
      read_valid     <= s1_rvalid;
      read_byte      <= s1_rvalid ? ram_q : 8'h00;
    end
  end

endmodule

// File: sv/sfp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
